// ===== design/vtp_pkg.sv =====
package vtp_pkg;

  localparam int DataWidth = 32;
  localparam int FracBits  = 16;
  localparam int NumRegs   = 8;
  localparam int AddrWidth = 6;

  localparam logic [63:0] RstColIXy = 64'd65536;
  localparam logic [63:0] RstColIZw = 64'd0;
  localparam logic [63:0] RstColJXy = 64'd281474976710656;
  localparam logic [63:0] RstColJZw = 64'd0;
  localparam logic [63:0] RstColKXy = 64'd0;
  localparam logic [63:0] RstColKZw = 64'd65536;
  localparam logic [63:0] RstColTXy = 64'd0;
  localparam logic [63:0] RstColTZw = 64'd281474976710656;

  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [31:0] in_w;
  } vtx_in_t;

  typedef struct packed {
    logic signed [31:0] hom_x;
    logic signed [31:0] hom_y;
    logic signed [31:0] hom_z;
    logic signed [31:0] hom_w;
    logic signed [31:0] cart_x;
    logic signed [31:0] cart_y;
    logic signed [31:0] cart_z;
    logic               w_is_zero;
  } vtx_out_t;

endpackage

// ===== design/vtp_dot_lane.sv =====
// one row of the matrix: four products, registered, then sum, floor shift, saturate
module vtp_dot_lane #(
  parameter int DATA_WIDTH = vtp_pkg::DataWidth,
  parameter int FRAC_BITS  = vtp_pkg::FracBits
) (
  input  logic                         clk_i,
  input  logic                         valid_i,
  input  logic signed [DATA_WIDTH-1:0] vec_i [4],
  input  logic signed [DATA_WIDTH-1:0] row_i [4],
  output logic signed [DATA_WIDTH-1:0] res_o
);
  localparam int PW = 2 * DATA_WIDTH;
  localparam int SW = PW + 2;

  logic signed [PW-1:0] prod_q [4];
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] shifted;
  logic signed [SW-1:0] max_v, min_v;

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      for (int c = 0; c < 4; c++) begin
        prod_q[c] <= PW'(row_i[c]) * PW'(vec_i[c]);
      end
    end
  end

  always_comb begin
    max_v   = SW'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    min_v   = -max_v - SW'(1);
    sum     = SW'(prod_q[0]) + SW'(prod_q[1]) + SW'(prod_q[2]) + SW'(prod_q[3]);
    shifted = sum >>> FRAC_BITS;
    if (shifted > max_v) begin
      res_o = max_v[DATA_WIDTH-1:0];
    end else if (shifted < min_v) begin
      res_o = min_v[DATA_WIDTH-1:0];
    end else begin
      res_o = shifted[DATA_WIDTH-1:0];
    end
  end
endmodule

// ===== design/vtp_div_lane.sv =====
// pipelined restoring divider, one quotient bit per stage, truncating toward zero
module vtp_div_lane #(
  parameter int DATA_WIDTH = vtp_pkg::DataWidth,
  parameter int FRAC_BITS  = vtp_pkg::FracBits
) (
  input  logic                         clk_i,
  input  logic                         en_i [DATA_WIDTH+FRAC_BITS+1],
  input  logic signed [DATA_WIDTH-1:0] num_i,
  input  logic signed [DATA_WIDTH-1:0] den_i,
  output logic signed [DATA_WIDTH-1:0] quo_o
);
  localparam int NW = DATA_WIDTH + FRAC_BITS;
  localparam int ST = NW;

  logic [NW-1:0]         n_q   [ST+1];
  logic [NW-1:0]         q_q   [ST+1];
  logic [DATA_WIDTH:0]   r_q   [ST+1];
  logic [DATA_WIDTH-1:0] d_q   [ST+1];
  logic                  neg_q [ST+1];
  logic [DATA_WIDTH-1:0] num_mag;

  assign num_mag = num_i[DATA_WIDTH-1] ? DATA_WIDTH'(-num_i) : DATA_WIDTH'(num_i);

  // stage 0 captures magnitudes
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      n_q[0]   <= {num_mag, {FRAC_BITS{1'b0}}};
      d_q[0]   <= den_i[DATA_WIDTH-1] ? DATA_WIDTH'(-den_i) : DATA_WIDTH'(den_i);
      neg_q[0] <= num_i[DATA_WIDTH-1] ^ den_i[DATA_WIDTH-1];
      q_q[0]   <= '0;
      r_q[0]   <= '0;
    end
  end

  for (genvar s = 0; s < ST; s++) begin : g_st
    logic [DATA_WIDTH+1:0] trial;
    logic [DATA_WIDTH+1:0] rsh;
    assign rsh   = {r_q[s], n_q[s][NW-1-s]};
    assign trial = rsh - {2'b00, d_q[s]};
    always_ff @(posedge clk_i) begin
      if (en_i[s+1]) begin
        n_q[s+1]   <= n_q[s];
        d_q[s+1]   <= d_q[s];
        neg_q[s+1] <= neg_q[s];
        if (!trial[DATA_WIDTH+1]) begin
          r_q[s+1] <= trial[DATA_WIDTH:0];
          q_q[s+1] <= q_q[s] | (NW'(1) << (NW-1-s));
        end else begin
          r_q[s+1] <= rsh[DATA_WIDTH:0];
          q_q[s+1] <= q_q[s];
        end
      end
    end
  end

  logic [NW:0] mag;
  logic [NW:0] lim;
  assign mag = {1'b0, q_q[ST]};
  always_comb begin
    lim = (NW+1)'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    if (!neg_q[ST]) begin
      quo_o = (mag > lim) ? lim[DATA_WIDTH-1:0] : mag[DATA_WIDTH-1:0];
    end else if (mag > lim) begin
      quo_o = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else begin
      quo_o = DATA_WIDTH'(-mag);
    end
  end
endmodule

// ===== design/vertex_transform_project.sv =====
// homogeneous 4x4 vertex transform with perspective divide, signed q16.16.
// a vertex is taken on any cycle with start_i high (busy_o is always low), so
// one vertex per clock is sustained. four dot-product lanes (one per output
// row) register their products, then sum, floor-shift and saturate: hom is
// ready the cycle after start. three pipelined bit-per-stage dividers then form
// cart = hom * 2^frac / hom_w, each divider having data+frac bit stages. a result beat is shown
// for one cycle with done_o and cannot be stalled by the receiver. the matrix
// sits in eight 64-bit apb registers at byte address 8*i; the user must make
// writes only while no vertex is in flight, which the block does not enforce.
module vertex_transform_project #(
  parameter int DATA_WIDTH = vtp_pkg::DataWidth,
  parameter int FRAC_BITS  = vtp_pkg::FracBits
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  vtp_pkg::vtx_in_t                   data_i,
  output logic                               done_o,
  output vtp_pkg::vtx_out_t                  data_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [vtp_pkg::AddrWidth-1:0]      paddr,
  input  logic [63:0]                        pwdata,
  output logic [63:0]                        prdata,
  output logic                               pready
);
  localparam int DS  = DATA_WIDTH + FRAC_BITS;
  localparam int LAT = DS + 2;

  // configuration registers
  logic [63:0] regs_q [vtp_pkg::NumRegs];
  logic [2:0]  ridx;
  logic        wr_en;
  assign ridx   = paddr[5:3];
  assign wr_en  = psel && penable && pwrite && (paddr[2:0] == 3'd0);
  assign pready = 1'b1;
  assign prdata = (paddr[2:0] == 3'd0) ? regs_q[ridx] : '0;
  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q[0] <= vtp_pkg::RstColIXy;
      regs_q[1] <= vtp_pkg::RstColIZw;
      regs_q[2] <= vtp_pkg::RstColJXy;
      regs_q[3] <= vtp_pkg::RstColJZw;
      regs_q[4] <= vtp_pkg::RstColKXy;
      regs_q[5] <= vtp_pkg::RstColKZw;
      regs_q[6] <= vtp_pkg::RstColTXy;
      regs_q[7] <= vtp_pkg::RstColTZw;
    end else if (wr_en) begin
      regs_q[ridx] <= pwdata;
    end
  end

  // valid shift line
  logic vld_q [LAT];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) vld_q[i] <= 1'b0;
    end else begin
      vld_q[0] <= start_i;
      for (int i = 1; i < LAT; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // vector and matrix elements, sign taken from low DATA_WIDTH bits
  logic signed [DATA_WIDTH-1:0] vec [4];
  logic signed [DATA_WIDTH-1:0] row [4][4];
  assign vec[0] = data_i.in_x[DATA_WIDTH-1:0];
  assign vec[1] = data_i.in_y[DATA_WIDTH-1:0];
  assign vec[2] = data_i.in_z[DATA_WIDTH-1:0];
  assign vec[3] = data_i.in_w[DATA_WIDTH-1:0];

  always_comb begin
    for (int e = 0; e < 4; e++) begin
      for (int c = 0; c < 4; c++) begin
        row[e][c] = (e % 2 == 1) ? regs_q[c*2 + e/2][32 +: DATA_WIDTH]
                                 : regs_q[c*2 + e/2][0 +: DATA_WIDTH];
      end
    end
  end

  logic signed [DATA_WIDTH-1:0] hom [4];
  for (genvar e = 0; e < 4; e++) begin : g_dot
    vtp_dot_lane #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dot (
      .clk_i   (clk_i),
      .valid_i (start_i),
      .vec_i   (vec),
      .row_i   (row[e]),
      .res_o   (hom[e])
    );
  end

  // hom and flag travel beside the divider
  logic signed [DATA_WIDTH-1:0] hom_q [DS+1][4];
  logic                         wz_q  [DS+1];
  always_ff @(posedge clk_i) begin
    if (vld_q[0]) begin
      hom_q[0] <= hom;
      wz_q[0]  <= (hom[3] == '0);
    end
    for (int s = 1; s <= DS; s++) begin
      if (vld_q[s]) begin
        hom_q[s] <= hom_q[s-1];
        wz_q[s]  <= wz_q[s-1];
      end
    end
  end

  logic en [DS+1];
  always_comb begin
    for (int s = 0; s <= DS; s++) en[s] = vld_q[s];
  end

  logic signed [DATA_WIDTH-1:0] quo [3];
  for (genvar e = 0; e < 3; e++) begin : g_div
    vtp_div_lane #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (hom[e]),
      .den_i ((hom[3] == '0) ? DATA_WIDTH'(1) : hom[3]),
      .quo_o (quo[e])
    );
  end

  // output merge
  assign done_o           = vld_q[LAT-1];
  assign data_o.hom_x     = 32'(hom_q[DS][0]);
  assign data_o.hom_y     = 32'(hom_q[DS][1]);
  assign data_o.hom_z     = 32'(hom_q[DS][2]);
  assign data_o.hom_w     = 32'(hom_q[DS][3]);
  assign data_o.cart_x    = wz_q[DS] ? '0 : 32'(quo[0]);
  assign data_o.cart_y    = wz_q[DS] ? '0 : 32'(quo[1]);
  assign data_o.cart_z    = wz_q[DS] ? '0 : 32'(quo[2]);
  assign data_o.w_is_zero = wz_q[DS];
endmodule

// ===== design/vtp_checker.sv =====
module vtp_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              busy_o,
  input logic              done_o,
  input vtp_pkg::vtx_out_t data_o
);
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");
  a_wz_cart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && data_o.w_is_zero |-> data_o.cart_x == 0 && data_o.cart_y == 0 &&
    data_o.cart_z == 0) else $error("cart nonzero with zero w");
  a_wz_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> data_o.w_is_zero == (data_o.hom_w == 0)) else $error("flag mismatch");
endmodule

bind vertex_transform_project vtp_checker u_vtp_checker (
  .clk_i (clk_i), .rst_ni (rst_ni), .busy_o (busy_o), .done_o (done_o), .data_o (data_o)
);
